// ===== rtl/core/fqm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqm_pkg: shared types and constants of the queued mutex
// Request and response beat layouts, status and mode codes, queue sizing and
// the write port record of the waiter store.
// ----------------------------------------------------------------------------
package fqm_pkg;

    localparam int QUEUE_DEPTH = 15;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 8;

    localparam logic [1:0] MODE_INIT   = 2'd0;
    localparam logic [1:0] MODE_LOCK   = 2'd1;
    localparam logic [1:0] MODE_UNLOCK = 2'd2;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_QUEUED        = 3'd1;
    localparam logic [2:0] ST_NOT_INIT      = 3'd2;
    localparam logic [2:0] ST_ALREADY_OWNER = 3'd3;
    localparam logic [2:0] ST_NOT_OWNER     = 3'd4;
    localparam logic [2:0] ST_FULL          = 3'd5;
    localparam logic [2:0] ST_ALREADY_INIT  = 3'd6;

    typedef struct packed {
        logic [1:0]      mode;
        logic [ID_W-1:0] thread_id;
    } req_t;

    typedef struct packed {
        logic [2:0]      status;
        logic            wake_valid;
        logic [ID_W-1:0] wake_id;
    } rsp_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [ID_W-1:0]  data;
    } qwr_t;

endpackage

// ===== rtl/core/fifo_queued_mutex.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queued_mutex: hardware mutex with a FIFO of waiting thread ids
// Request register, combinational decision and response register.
// ----------------------------------------------------------------------------
// A request beat (mode, thread_id) is captured in an input register and
// decided there, against the owner, the initialised flag and a 15-entry
// circular queue of waiters. Its response beat is then loaded into an output
// register and offered from there. One request is handled per cycle, so the
// block sustains one beat per clock while responses are taken.
// While a response waits untaken, the next request that has a response is
// held in the input register, and the request side stalls until the output
// register is freed. A request with the unused mode 3 is consumed without a
// response. Queue slots are held in plain registers with no reset.
module fifo_queued_mutex (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  fqm_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output fqm_pkg::rsp_t  rsp
);

    logic                        in_valid_reg;
    fqm_pkg::req_t               in_data_reg;
    logic                        out_valid_reg;
    fqm_pkg::rsp_t               out_data_reg;
    logic                        out_free;
    logic                        has_rsp;
    logic                        fire;
    logic [fqm_pkg::IDX_W-1:0]   head_idx;
    logic [fqm_pkg::ID_W-1:0]    head_data;
    fqm_pkg::qwr_t               qwr;
    fqm_pkg::rsp_t               rsp_next;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign has_rsp   = (in_data_reg.mode == fqm_pkg::MODE_INIT)
                    || (in_data_reg.mode == fqm_pkg::MODE_LOCK)
                    || (in_data_reg.mode == fqm_pkg::MODE_UNLOCK);
    // A beat with no response never waits for the output side.
    assign fire      = in_valid_reg && (out_free || !has_rsp);
    assign req_ready = !in_valid_reg || fire;

    fqm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .req       (in_data_reg),
        .head_data (head_data),
        .head_idx  (head_idx),
        .wr        (qwr),
        .rsp       (rsp_next)
    );

    fqm_queue u_queue (
        .clk     (clk),
        .wr      (qwr),
        .rd_addr (head_idx),
        .rd_data (head_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                in_valid_reg <= req_valid;
            end
            if (fire && has_rsp)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            in_data_reg <= req;
        end
        if (fire && has_rsp)
        begin
            out_data_reg <= rsp_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

endmodule

// ===== rtl/core/fqm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqm_queue: waiter id store
// One slot per queue entry, written at the tail and read at the head.
// ----------------------------------------------------------------------------
module fqm_queue (
    input  logic                         clk,
    input  fqm_pkg::qwr_t                wr,
    input  logic [fqm_pkg::IDX_W-1:0]    rd_addr,
    output logic [fqm_pkg::ID_W-1:0]     rd_data
);

    logic [fqm_pkg::ID_W-1:0] slot_reg [fqm_pkg::QUEUE_DEPTH];

    // Slots hold no meaning until a lock has written them, so no reset.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            slot_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_data = slot_reg[rd_addr];

endmodule

// ===== rtl/core/fqm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqm_ctrl: mutex state and request decision
// Holds the initialised flag, owner id and queue pointers, and works out the
// response and state update for one request combinationally.
// ----------------------------------------------------------------------------
module fqm_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  fqm_pkg::req_t                req,
    input  logic [fqm_pkg::ID_W-1:0]     head_data,
    output logic [fqm_pkg::IDX_W-1:0]    head_idx,
    output fqm_pkg::qwr_t                wr,
    output fqm_pkg::rsp_t                rsp
);

    logic                        is_valid_reg, is_valid_next;
    logic [fqm_pkg::ID_W-1:0]    owner_reg, owner_next;
    logic [fqm_pkg::IDX_W-1:0]   head_reg, head_next;
    logic [fqm_pkg::IDX_W-1:0]   tail_reg, tail_next;
    logic [fqm_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [fqm_pkg::IDX_W-1:0]   head_inc, tail_inc;
    logic                        queue_full, queue_empty;

    assign head_inc = (head_reg == fqm_pkg::IDX_W'(fqm_pkg::QUEUE_DEPTH - 1))
                    ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == fqm_pkg::IDX_W'(fqm_pkg::QUEUE_DEPTH - 1))
                    ? '0 : tail_reg + 1'b1;
    assign queue_full  = (count_reg == fqm_pkg::CNT_W'(fqm_pkg::QUEUE_DEPTH));
    assign queue_empty = (count_reg == '0);
    assign head_idx    = head_reg;

    always_comb
    begin
        is_valid_next  = is_valid_reg;
        owner_next     = owner_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        wr.en          = 1'b0;
        wr.addr        = tail_reg;
        wr.data        = req.thread_id;
        rsp.status     = fqm_pkg::ST_OK;
        rsp.wake_valid = 1'b0;
        rsp.wake_id    = '0;

        case (req.mode)
            fqm_pkg::MODE_INIT:
            begin
                if (is_valid_reg)
                begin
                    rsp.status = fqm_pkg::ST_ALREADY_INIT;
                end
                else
                begin
                    is_valid_next = 1'b1;
                    owner_next    = '0;
                    head_next     = '0;
                    tail_next     = '0;
                    count_next    = '0;
                end
            end
            fqm_pkg::MODE_LOCK:
            begin
                if (!is_valid_reg)
                begin
                    rsp.status = fqm_pkg::ST_NOT_INIT;
                end
                else if (owner_reg == req.thread_id)
                begin
                    rsp.status = fqm_pkg::ST_ALREADY_OWNER;
                end
                else if (owner_reg == '0 && queue_empty)
                begin
                    owner_next = req.thread_id;
                end
                else if (!queue_full)
                begin
                    // A free mutex with waiters still queues the newcomer.
                    wr.en      = 1'b1;
                    tail_next  = tail_inc;
                    count_next = count_reg + 1'b1;
                    rsp.status = fqm_pkg::ST_QUEUED;
                end
                else
                begin
                    rsp.status = fqm_pkg::ST_FULL;
                end
            end
            fqm_pkg::MODE_UNLOCK:
            begin
                if (!is_valid_reg)
                begin
                    rsp.status = fqm_pkg::ST_NOT_INIT;
                end
                else if (owner_reg != req.thread_id)
                begin
                    rsp.status = fqm_pkg::ST_NOT_OWNER;
                end
                else if (queue_empty)
                begin
                    owner_next = '0;
                end
                else
                begin
                    owner_next     = head_data;
                    head_next      = head_inc;
                    count_next     = count_reg - 1'b1;
                    rsp.wake_valid = 1'b1;
                    rsp.wake_id    = head_data;
                end
            end
            default:
            begin
                // Unused mode: consumed without effect or response.
            end
        endcase

        if (!fire)
        begin
            wr.en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_valid_reg <= 1'b0;
            owner_reg    <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
        end
        else if (fire)
        begin
            is_valid_reg <= is_valid_next;
            owner_reg    <= owner_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
        end
    end

endmodule

// ===== tb/fqm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqm_checker: response predictor and scoreboard for the queued mutex
// Watches both channels. It tracks the owner, the initialised flag and the
// ring of waiters for every request beat taken, and compares each response
// beat taken with the oldest predicted one.
// ----------------------------------------------------------------------------
module fqm_checker
    import fqm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_ready,
    input  req_t            req,
    input  logic            rsp_valid,
    input  logic            rsp_ready,
    input  rsp_t            rsp,
    output int              fail_count,
    output int              pending,
    output logic [ID_W-1:0] holder
);

    logic            inited;
    logic [ID_W-1:0] owner;
    logic [ID_W-1:0] waiter_ids [QUEUE_DEPTH];
    int              head;
    int              tail;
    int              waiting;
    int              fails;
    rsp_t            due_rsp [$];

    function automatic int wrap_next(input int i);
        return (i + 1 >= QUEUE_DEPTH) ? 0 : i + 1;
    endfunction

    task automatic note_failure(input string what, input rsp_t want, input rsp_t got);
        fails++;
        if (fails <= 10)
        begin
            $display("%t %s: expected status %0d wake_valid %0d wake_id %0d,",
                     $realtime, what, want.status, want.wake_valid, want.wake_id);
            $display("    got status %0d wake_valid %0d wake_id %0d",
                     got.status, got.wake_valid, got.wake_id);
        end
    endtask

    // Works out the response of one request beat and updates the mutex state.
    task automatic decide(input req_t r);
        rsp_t d;
        d = '0;
        d.status = ST_OK;
        case (r.mode)
            MODE_INIT:
            begin
                if (inited)
                begin
                    d.status = ST_ALREADY_INIT;
                end
                else
                begin
                    // The waiter slots keep their contents across an init.
                    inited  = 1'b1;
                    owner   = '0;
                    head    = 0;
                    tail    = 0;
                    waiting = 0;
                end
            end
            MODE_LOCK:
            begin
                if (!inited)
                begin
                    d.status = ST_NOT_INIT;
                end
                else if (owner == r.thread_id)
                begin
                    d.status = ST_ALREADY_OWNER;
                end
                else if (owner == '0 && waiting == 0)
                begin
                    owner = r.thread_id;
                end
                else if (waiting < QUEUE_DEPTH)
                begin
                    waiter_ids[tail] = r.thread_id;
                    tail             = wrap_next(tail);
                    waiting++;
                    d.status = ST_QUEUED;
                end
                else
                begin
                    d.status = ST_FULL;
                end
            end
            MODE_UNLOCK:
            begin
                if (!inited)
                begin
                    d.status = ST_NOT_INIT;
                end
                else if (owner != r.thread_id)
                begin
                    d.status = ST_NOT_OWNER;
                end
                else if (waiting == 0)
                begin
                    owner = '0;
                end
                else
                begin
                    owner = waiter_ids[head];
                    head  = wrap_next(head);
                    waiting--;
                    d.wake_valid = 1'b1;
                    d.wake_id    = owner;
                end
            end
            default:
            begin
                // The unused mode is swallowed without a response.
                return;
            end
        endcase
        due_rsp.push_back(d);
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            inited  = 1'b0;
            owner   = '0;
            head    = 0;
            tail    = 0;
            waiting = 0;
            fails   = 0;
            due_rsp.delete();
        end
        else
        begin
            // A response taken at this edge always belongs to an older request,
            // so it is checked before the request of the same edge is added.
            if (rsp_valid && rsp_ready)
            begin
                if (due_rsp.size() == 0)
                begin
                    note_failure("unexpected response beat", '0, rsp);
                end
                else
                begin
                    want = due_rsp.pop_front();
                    if (rsp.status != want.status || rsp.wake_valid != want.wake_valid ||
                        rsp.wake_id != want.wake_id)
                    begin
                        note_failure("response mismatch", want, rsp);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                decide(req);
            end
        end
        fail_count <= fails;
        pending    <= due_rsp.size();
        holder     <= owner;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression of the queued mutex
// Drives a directed run through the corner cases of init, lock and unlock,
// then a long random run with bursty idling on both channels, a long
// receiver hold-off and a full drain, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
    import fqm_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 2000;
    localparam int QUIET_TAIL   = 200;
    localparam int SEGMENT      = 64;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_AT     = 1200;
    localparam int END_LIMIT    = 2000;

    logic            clk;
    logic            rst_n;
    logic            req_valid;
    logic            req_ready;
    req_t            req;
    logic            rsp_valid;
    logic            rsp_ready;
    rsp_t            rsp;
    int              fail_count;
    int              pending;
    logic [ID_W-1:0] holder;

    int              item_no;
    int              send_idle_pct;
    logic [ID_W-1:0] id_pool [4];

    fifo_queued_mutex dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    fqm_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending),
        .holder     (holder)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("fifo_queued_mutex regression: fail");
        $finish;
    end

    // Offers one request beat, after an optional idle burst, and returns at
    // the edge where it is taken.
    task automatic send_beat(input logic [1:0] op, input logic [ID_W-1:0] tid);
        int gap;
        if (item_no < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(14, 1);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{mode: op, thread_id: tid};
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    function automatic logic [ID_W-1:0] pool_id();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            return '0;
        end
        else if (pick < 30)
        begin
            return '1;
        end
        return ID_W'($urandom_range(255));
    endfunction

    // Receiver: random stall bursts, one long hold-off, and none at the end.
    initial
    begin
        int  stall;
        int  run;
        bit  held;
        stall = 0;
        run   = 0;
        held  = 1'b0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && item_no >= HOLD_AT)
            begin
                held = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (item_no >= RANDOM_ITEMS - QUIET_TAIL)
            begin
                rsp_ready <= 1'b1;
            end
            else if (stall > 0)
            begin
                stall--;
                rsp_ready <= 1'b0;
            end
            else if (run > 0)
            begin
                run--;
                rsp_ready <= 1'b1;
            end
            else if ($urandom_range(99) < 30)
            begin
                stall = $urandom_range(14, 1) - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                run = $urandom_range(30, 1) - 1;
                rsp_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int          counted;
        int          beats;
        int          lock_pct;
        int          pick;
        int          waited;
        bit          drained;
        logic [1:0]  op;
        logic [ID_W-1:0] tid;
        counted = 0;
        beats   = 0;
        drained = 1'b0;
        lock_pct = 50;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        item_no   <= 0;
        send_idle_pct = 20;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: requests before init, the unused mode, double init,
        // id 0 against a free mutex, then a full queue and handovers.
        send_beat(MODE_LOCK, 8'd1);
        send_beat(MODE_UNLOCK, 8'd1);
        send_beat(MODE_UNUSED, 8'hA5);
        send_beat(MODE_INIT, 8'h00);
        send_beat(MODE_INIT, 8'hFF);
        send_beat(MODE_LOCK, 8'h00);
        send_beat(MODE_LOCK, 8'd5);
        send_beat(MODE_LOCK, 8'd5);
        send_beat(MODE_UNLOCK, 8'd7);
        // The first waiter has id 0, so the first handover wakes id 0.
        send_beat(MODE_LOCK, 8'h00);
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
        begin
            send_beat(MODE_LOCK, (i < 2) ? 8'hFF : ID_W'(8'h80 + i));
        end
        send_beat(MODE_LOCK, 8'h42);
        send_beat(MODE_UNLOCK, 8'd5);
        // Owner is now id 0 with waiters left: a new lock queues behind them.
        send_beat(MODE_LOCK, 8'd9);
        send_beat(MODE_UNLOCK, 8'h00);

        while (counted < RANDOM_ITEMS)
        begin
            if (beats % SEGMENT == 0)
            begin
                lock_pct = $urandom_range(80, 30);
                case ($urandom_range(2))
                    0: send_idle_pct = 0;
                    1: send_idle_pct = 15;
                    default: send_idle_pct = 35;
                endcase
                for (int i = 0; i < 4; i++)
                begin
                    id_pool[i] = pool_id();
                end
            end
            if (!drained && counted >= DRAIN_AT)
            begin
                drained = 1'b1;
                req_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end

            pick = $urandom_range(99);
            tid  = id_pool[$urandom_range(3)];
            if (pick < 3)
            begin
                op = MODE_INIT;
            end
            else if (pick < 6)
            begin
                op = MODE_UNUSED;
            end
            else if ($urandom_range(99) < lock_pct)
            begin
                op = MODE_LOCK;
            end
            else
            begin
                op = MODE_UNLOCK;
                // Mostly unlock as the current owner so that handovers happen.
                if ($urandom_range(99) < 70)
                begin
                    tid = holder;
                end
            end
            send_beat(op, tid);
            beats++;
            if (op != MODE_UNUSED)
            begin
                counted++;
            end
            item_no <= counted;
        end
        req_valid <= 1'b0;
        @(posedge clk);

        waited = 0;
        while (pending != 0 && waited < END_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("fifo_queued_mutex regression: pass");
        end
        else
        begin
            $display("fifo_queued_mutex regression: fail");
        end
        $finish;
    end

endmodule
